// ----- sv/lcm_pkg.sv -----
// Package for the line counting turn maneuver block: codes, state types,
// timing constants and small helper functions.
// No dependencies; imported by lcm_div, lcm_xdet and the top level.
package lcm_pkg;

  // serial divider geometry
  localparam int DIV_W     = 12;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int DVS_W     = 4;

  // line counting
  localparam int LINES_W   = 4;
  localparam int MAX_LINES = 15;

  // timing constants in milliseconds, and the angle limit
  localparam logic [11:0] TURN_BASE_MS   = 12'd800;
  localparam logic [12:0] BOOST_MS       = 13'd200;
  localparam logic [15:0] FINAL_EXTRA_MS = 16'd100;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [7:0]  ANGLE_MAX      = 8'd180;

  // configuration register indexes
  localparam logic [2:0] CFG_STRAIGHT_ANGLE = 3'd0;
  localparam logic [2:0] CFG_TURN_ANGLE     = 3'd1;
  localparam logic [2:0] CFG_SECOND_DIV     = 3'd2;
  localparam logic [2:0] CFG_CRUISE_SPEED   = 3'd3;
  localparam logic [2:0] CFG_TURNING_SPEED  = 3'd4;
  localparam logic [2:0] CFG_MAX_TURN_MS    = 3'd5;
  localparam logic [2:0] CFG_MIN_TURN_MS    = 3'd6;
  localparam logic [2:0] CFG_CROSS_GUARD_MS = 3'd7;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_FWD   = 2'd2,
    CMD_BACK  = 2'd3
  } cmd_t;

  // drive direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // reported status codes
  localparam logic [2:0] STS_IDLE       = 3'd0;
  localparam logic [2:0] STS_FIRST      = 3'd1;
  localparam logic [2:0] STS_FIRST_OVER = 3'd2;
  localparam logic [2:0] STS_COUNT      = 3'd3;
  localparam logic [2:0] STS_FINAL      = 3'd4;
  localparam logic [2:0] STS_FINAL_OVER = 3'd5;

  // maneuver phase; the code doubles as the reported status
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIRST = 3'd1,
    PH_COUNT = 3'd3,
    PH_FINAL = 3'd4
  } phase_t;

  // two-sensor crossing detector state
  typedef enum logic [2:0] {
    XS_BOTH_EXP      = 3'd0,
    XS_FIRST_DET     = 3'd1,
    XS_PASS_SEC_EXP  = 3'd2,
    XS_BOTH_DET      = 3'd3,
    XS_PASS_SEC_DET  = 3'd4
  } xstate_t;

  // item sequencer
  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_DIV    = 2'd1,
    SQ_COMMIT = 2'd2
  } seq_t;

  // detector result
  typedef struct packed {
    xstate_t nxt;
    logic    line_done;
  } xdet_res_t;

  // saturate a signed angle to 0..180
  function automatic logic [7:0] clamp_angle(input logic signed [9:0] a);
    logic [7:0] r;
    if (a < 0) r = 8'd0;
    else if (a > $signed({2'b00, ANGLE_MAX})) r = ANGLE_MAX;
    else r = a[7:0];
    return r;
  endfunction

  // straight angle plus or minus a steering offset, saturated
  function automatic logic [7:0] steer_calc(input logic [7:0] straight,
                                            input logic [6:0] offset,
                                            input logic left);
    logic signed [9:0] s;
    logic signed [9:0] o;
    s = $signed({2'b00, straight});
    o = $signed({3'b000, offset});
    return clamp_angle(left ? s - o : s + o);
  endfunction

  // lines to count from the signed distance: |d| - 1, zero treated as one
  function automatic logic [LINES_W-1:0] calc_target(input logic signed [4:0] d);
    logic [4:0] mag;
    logic [4:0] tgt;
    mag = d[4] ? (~d + 5'd1) : d;
    if (mag == 5'd0) mag = 5'd1;
    tgt = mag - 5'd1;
    if ({27'd0, tgt} > 32'(MAX_LINES)) tgt = 5'(MAX_LINES);
    return tgt[LINES_W-1:0];
  endfunction

endpackage

// ----- sv/lcm_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on lcm_pkg for its widths.
module lcm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lcm_pkg::DIV_W-1:0]   dividend,
  input  logic [lcm_pkg::DVS_W-1:0]   divisor,
  output logic [lcm_pkg::DIV_W-1:0]   quotient,
  output logic                        done
);
  import lcm_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       rem_sh;
  logic                 ge;

  // one shift-and-subtract step
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- sv/lcm_xdet.sv -----
// Five-state crossing detector for a line passed diagonally by two sensors.
// Depends on lcm_pkg for the state type.
module lcm_xdet (
  input  lcm_pkg::xstate_t   cur,
  input  logic               lead,
  input  logic               trail,
  output lcm_pkg::xdet_res_t res
);
  import lcm_pkg::*;

  // leading sensor sees the line first, trailing one second
  always_comb begin
    res.nxt       = cur;
    res.line_done = 1'b0;
    unique case (cur)
      XS_BOTH_EXP: begin
        if (lead) res.nxt = XS_FIRST_DET;
      end
      XS_FIRST_DET: begin
        if (!lead && !trail) res.nxt = XS_PASS_SEC_EXP;
        else if (lead && trail) res.nxt = XS_BOTH_DET;
      end
      XS_PASS_SEC_EXP: begin
        if (!lead && trail) res.nxt = XS_PASS_SEC_DET;
      end
      XS_BOTH_DET: begin
        if (!lead) res.nxt = XS_PASS_SEC_DET;
      end
      XS_PASS_SEC_DET: begin
        if (!lead && !trail) begin
          res.nxt       = XS_BOTH_EXP;
          res.line_done = 1'b1;
        end
      end
      default: res.nxt = XS_BOTH_EXP;
    endcase
  end

endmodule

// ----- sv/line_counting_turn_maneuver.sv -----
// Top level of the line counting turn maneuver: configuration registers,
// item sequencer, maneuver state and output register.
// Depends on lcm_pkg, lcm_div and lcm_xdet.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in_     | sink      | in_tvalid/in_tready   | tuser cmd, tdata sensors/dist
//   out_    | source    | out_tvalid/out_tready | tdata status and drive values
//   cfg_    | sink      | cfg_valid/cfg_ready   | cfg_addr index, cfg_data value
//
// Each item is latched at accept, divided in the bit-serial divider (turn
// time on start, counter-turn offset otherwise) and committed once the
// output register is free. One item is in work at a time; a result may
// wait in the output register while the next item is accepted and divided.
// Reset is synchronous and clears all control and maneuver state.
// Configuration writes are always taken.
module line_counting_turn_maneuver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] distance, [5] left_sensor, [6] right_sensor
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] status, [10:3] steer_angle,
                                  // [18:11] drive_speed, [20:19] drive_dir,
                                  // [24:21] lines_seen
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_data
);
  import lcm_pkg::*;

  // configuration registers
  logic [7:0]  straight_r, cruise_r, turnspd_r;
  logic [6:0]  turn_ang_r;
  logic [3:0]  sec_div_r;
  logic [11:0] max_ms_r, min_ms_r, guard_r;

  // latched item
  cmd_t              cmd_r;
  logic signed [4:0] dist_r;
  logic              lsen_r, rsen_r;

  // maneuver state
  phase_t             phase_r, phase_nxt;
  xstate_t            xst_r, xst_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [12:0]        tdur_r, tdur_nxt;
  logic [LINES_W-1:0] target_r, target_nxt;
  logic [LINES_W-1:0] count_r, count_nxt;
  logic               first_left_r, first_left_nxt;
  logic               boost_r, boost_nxt;
  logic [7:0]         steer_r, steer_nxt;
  logic [7:0]         speed_r, speed_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [2:0]         status_c;

  // sequencer and output register
  seq_t        seq_r, seq_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        accept, commit, div_start, div_done;

  // divider operands
  logic [DIV_W-1:0]   span_c, dividend_c, quotient;
  logic [DVS_W-1:0]   divisor_c;
  logic [LINES_W-1:0] tgt_in, tgt_c;

  // tick evaluation
  logic [15:0] el_inc;
  logic        sense_en, lead, trail, ct;
  xdet_res_t   xres;
  logic [LINES_W-1:0] count_inc;
  logic [12:0] tturn;
  logic [7:0]  straight_sat;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_r <= 8'd90;
      turn_ang_r <= 7'd30;
      sec_div_r  <= 4'd2;
      cruise_r   <= 8'd200;
      turnspd_r  <= 8'd150;
      max_ms_r   <= 12'd2000;
      min_ms_r   <= 12'd500;
      guard_r    <= 12'd200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_STRAIGHT_ANGLE: straight_r <= cfg_data[7:0];
        CFG_TURN_ANGLE:     turn_ang_r <= cfg_data[6:0];
        CFG_SECOND_DIV:     sec_div_r  <= cfg_data[3:0];
        CFG_CRUISE_SPEED:   cruise_r   <= cfg_data[7:0];
        CFG_TURNING_SPEED:  turnspd_r  <= cfg_data[7:0];
        CFG_MAX_TURN_MS:    max_ms_r   <= cfg_data;
        CFG_MIN_TURN_MS:    min_ms_r   <= cfg_data;
        CFG_CROSS_GUARD_MS: guard_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider operands chosen at accept
  assign tgt_in = calc_target($signed(in_tdata[4:0]));
  assign span_c = (max_ms_r > TURN_BASE_MS) ? (max_ms_r - TURN_BASE_MS) : '0;

  always_comb begin
    if (cmd_t'(in_tuser) == CMD_START) begin
      dividend_c = span_c;
      divisor_c  = (tgt_in == '0) ? DVS_W'(1) : DVS_W'(tgt_in);
    end else begin
      dividend_c = DIV_W'(turn_ang_r);
      divisor_c  = (sec_div_r == '0) ? DVS_W'(1) : sec_div_r;
    end
  end

  lcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend_c),
    .divisor  (divisor_c),
    .quotient (quotient),
    .done     (div_done)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_tuser);
      dist_r <= $signed(in_tdata[4:0]);
      lsen_r <= in_tdata[5];
      rsen_r <= in_tdata[6];
    end
  end

  // sequencer: next state and handshake
  always_comb begin
    seq_nxt   = seq_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (seq_r)
      SQ_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          div_start = 1'b1;
          seq_nxt   = SQ_DIV;
        end
      end
      SQ_DIV: begin
        if (div_done) seq_nxt = SQ_COMMIT;
      end
      SQ_COMMIT: begin
        if (!out_valid_r || out_tready) begin
          commit  = 1'b1;
          seq_nxt = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seq_r <= SQ_IDLE;
    else        seq_r <= seq_nxt;
  end

  // crossing detector on the latched sensors
  assign lead  = first_left_r ? lsen_r : rsen_r;
  assign trail = first_left_r ? rsen_r : lsen_r;

  lcm_xdet u_xdet (
    .cur   (xst_r),
    .lead  (lead),
    .trail (trail),
    .res   (xres)
  );

  assign el_inc = (phase_r != PH_IDLE && elapsed_r != ELAPSED_MAX) ?
                  elapsed_r + 16'd1 : elapsed_r;
  assign sense_en     = el_inc >= {4'd0, guard_r};
  assign count_inc    = count_r + 1'b1;
  assign tgt_c        = calc_target(dist_r);
  assign tturn        = {1'b0, TURN_BASE_MS} + 13'(quotient);
  assign straight_sat = (straight_r > ANGLE_MAX) ? ANGLE_MAX : straight_r;

  // maneuver update for the latched item
  always_comb begin
    phase_nxt      = phase_r;
    xst_nxt        = xst_r;
    elapsed_nxt    = elapsed_r;
    tdur_nxt       = tdur_r;
    target_nxt     = target_r;
    count_nxt      = count_r;
    first_left_nxt = first_left_r;
    boost_nxt      = boost_r;
    steer_nxt      = steer_r;
    speed_nxt      = speed_r;
    dir_nxt        = dir_r;
    status_c       = phase_r;
    ct             = 1'b0;
    unique case (cmd_r)
      CMD_START: begin
        target_nxt  = tgt_c;
        count_nxt   = '0;
        xst_nxt     = XS_BOTH_EXP;
        elapsed_nxt = '0;
        phase_nxt   = PH_FIRST;
        if (tgt_c == '0) begin
          tdur_nxt  = boost_r ? {1'b0, min_ms_r} : {1'b0, min_ms_r} + BOOST_MS;
          boost_nxt = 1'b1;
        end else begin
          tdur_nxt = (tturn > {1'b0, max_ms_r}) ? {1'b0, max_ms_r} : tturn;
        end
        first_left_nxt = dist_r[4];
        steer_nxt      = steer_calc(straight_r, turn_ang_r, dist_r[4]);
        speed_nxt      = turnspd_r;
        dir_nxt        = DIR_FWD;
        status_c       = STS_FIRST;
      end
      CMD_FWD, CMD_BACK: begin
        steer_nxt = straight_sat;
        speed_nxt = cruise_r;
        dir_nxt   = (cmd_r == CMD_FWD) ? DIR_FWD : DIR_BACK;
      end
      default: begin
        elapsed_nxt = el_inc;
        if (phase_r == PH_FIRST && el_inc > {3'd0, tdur_r}) begin
          steer_nxt = straight_sat;
          speed_nxt = cruise_r;
          dir_nxt   = DIR_FWD;
          phase_nxt = PH_COUNT;
          ct        = (target_r == '0);
          status_c  = STS_FIRST_OVER;
        end else if (phase_r == PH_FIRST || phase_r == PH_COUNT) begin
          if (sense_en) begin
            xst_nxt = xres.nxt;
            if (xres.line_done) begin
              count_nxt = count_inc;
              ct        = (count_inc == target_r);
            end
          end
          status_c = (phase_r == PH_FIRST) ? STS_FIRST : STS_COUNT;
        end else if (phase_r == PH_FINAL) begin
          if (el_inc > {3'd0, tdur_r} + FINAL_EXTRA_MS) begin
            steer_nxt = straight_sat;
            speed_nxt = cruise_r;
            dir_nxt   = DIR_FWD;
            phase_nxt = PH_IDLE;
            status_c  = STS_FINAL_OVER;
          end else begin
            status_c = STS_FINAL;
          end
        end else begin
          phase_nxt = PH_IDLE;
          status_c  = STS_IDLE;
        end
        // counter-turn to the other side with the reduced offset
        if (ct) begin
          phase_nxt   = PH_FINAL;
          elapsed_nxt = '0;
          steer_nxt   = steer_calc(straight_r, quotient[6:0], !first_left_r);
          speed_nxt   = turnspd_r;
          dir_nxt     = DIR_FWD;
        end
      end
    endcase
  end

  // maneuver state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      xst_r        <= XS_BOTH_EXP;
      elapsed_r    <= '0;
      tdur_r       <= '0;
      target_r     <= '0;
      count_r      <= '0;
      first_left_r <= 1'b0;
      boost_r      <= 1'b0;
      steer_r      <= 8'd90;
      speed_r      <= '0;
      dir_r        <= DIR_STOP;
    end else if (commit) begin
      phase_r      <= phase_nxt;
      xst_r        <= xst_nxt;
      elapsed_r    <= elapsed_nxt;
      tdur_r       <= tdur_nxt;
      target_r     <= target_nxt;
      count_r      <= count_nxt;
      first_left_r <= first_left_nxt;
      boost_r      <= boost_nxt;
      steer_r      <= steer_nxt;
      speed_r      <= speed_nxt;
      dir_r        <= dir_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {7'd0, count_nxt, dir_nxt, speed_nxt, steer_nxt, status_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/lcm_chk.sv -----
// Port-level checker for the line counting turn maneuver, bound to the top.
// Depends only on the top level's ports.
module lcm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken during work");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd6 && out_tdata[2:0] != 3'd7)
    else $error("bad status code");

  // steering saturated
  a_steer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:3] <= 8'd180)
    else $error("steer angle out of range");

  // direction code in range
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:19] != 2'd3)
    else $error("bad drive direction");

endmodule

bind line_counting_turn_maneuver lcm_chk u_lcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
